[src/mstt_pkg.sv]
// Shared types, opcodes and widths for the multi-slot tick timer table.
`timescale 1ns / 1ps

package mstt_pkg;

    // Default table depth
    localparam int NUM_SLOTS_DEF = 32;

    // Field widths of the request and result channels
    localparam int OP_W         = 2;
    localparam int TIMEOUT_W    = 32;
    localparam int SLOT_FIELD_W = 5;
    localparam int MASK_W       = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_tick;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

[src/mstt_ctrl.sv]
// Controller state machine sequencing request execution and the tick scan.
`timescale 1ns / 1ps

module mstt_ctrl import mstt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.op_tick ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A result is only pushed when the output register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded while output register occupied");

    // An accepted request is always executed on the following cycle
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");

    // The scan only advances while no request can be accepted
    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_step |-> o_stall)
        else $error("scan step while input open");

endmodule

[src/mstt_dp.sv]
// Datapath: slot valid bits, slot memory, tick writeback and result registers.
`timescale 1ns / 1ps

module mstt_dp import mstt_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [TIMEOUT_W-1:0]    i_timeout_ticks,
    input  logic                    i_periodic_mode,
    input  logic [SLOT_FIELD_W-1:0] i_target_slot,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic                    o_status,
    output logic [SLOT_FIELD_W-1:0] o_assigned_slot,
    output logic [MASK_W-1:0]       o_fired_mask
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int ENTRY_W = 1 + 2 * TIMEOUT_W;
    localparam int CMP_W   = 8;

    // Latched request
    logic [OP_W-1:0]         r_op;
    logic [TIMEOUT_W-1:0]    r_timeout;
    logic                    r_periodic;
    logic [SLOT_FIELD_W-1:0] r_target;

    // Slot state
    logic [NUM_SLOTS-1:0]    r_valid;
    logic [ENTRY_W-1:0]      r_mem [NUM_SLOTS];

    // Scan pipeline
    logic [SLOT_W-1:0]       r_scan_idx;
    logic [SLOT_W-1:0]       r_wb_idx;
    logic                    r_wb_pend;
    logic [ENTRY_W-1:0]      r_rd_data;

    // Pending result
    logic                    r_res_status;
    logic [SLOT_FIELD_W-1:0] r_res_slot;
    logic [MASK_W-1:0]       r_res_mask;

    // Output register
    logic                    r_out_valid;
    logic                    r_out_status;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic [MASK_W-1:0]       r_out_mask;

    logic [NUM_SLOTS-1:0]    w_free;
    logic [NUM_SLOTS-1:0]    w_lowest;
    logic                    w_full;
    logic [SLOT_W-1:0]       w_free_idx;
    logic [SLOT_W-1:0]       w_tgt_idx;
    logic                    w_tgt_ok;
    logic                    w_do_reg;
    logic                    w_do_unreg;
    logic                    w_rd_per;
    logic [TIMEOUT_W-1:0]    w_rd_to;
    logic [TIMEOUT_W-1:0]    w_rd_cnt;
    logic                    w_wb_live;
    logic                    w_wb_fire;
    logic [TIMEOUT_W-1:0]    w_wb_cnt;
    logic [MASK_W-1:0]       w_fire_bits;

    // Isolate the lowest free slot and encode it
    assign w_free   = ~r_valid;
    assign w_lowest = w_free & (~w_free + NUM_SLOTS'(1));
    assign w_full   = ~|w_free;

    always_comb begin
        w_free_idx = '0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (w_lowest[j]) begin
                w_free_idx = w_free_idx | SLOT_W'(j);
            end
        end
    end

    // Range-check the unregister target
    assign w_tgt_ok  = (CMP_W'(r_target) < CMP_W'(NUM_SLOTS));
    assign w_tgt_idx = SLOT_W'(r_target);

    // Decode the execute step
    always_comb begin
        w_do_reg   = 1'b0;
        w_do_unreg = 1'b0;
        unique case (r_op)
            OP_REGISTER:   w_do_reg   = i_cmd.exec && !w_full;
            OP_UNREGISTER: w_do_unreg = i_cmd.exec && w_tgt_ok;
            default: begin
                w_do_reg   = 1'b0;
                w_do_unreg = 1'b0;
            end
        endcase
    end

    // Evaluate the slot read on the previous scan step
    assign w_rd_per  = r_rd_data[ENTRY_W-1];
    assign w_rd_to   = r_rd_data[2*TIMEOUT_W-1:TIMEOUT_W];
    assign w_rd_cnt  = r_rd_data[TIMEOUT_W-1:0];
    assign w_wb_live = r_wb_pend && r_valid[r_wb_idx];
    assign w_wb_fire = w_wb_live && (w_rd_cnt >= w_rd_to);
    assign w_wb_cnt  = w_wb_fire ? TIMEOUT_W'(1) : (w_rd_cnt + TIMEOUT_W'(1));

    always_comb begin
        w_fire_bits = '0;
        for (int j = 0; j < MASK_W; j++) begin
            if ((j < NUM_SLOTS) && (r_wb_idx == SLOT_W'(j))) begin
                w_fire_bits[j] = w_wb_fire;
            end
        end
    end

    // Latch the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_operation;
            r_timeout  <= i_timeout_ticks;
            r_periodic <= i_periodic_mode;
            r_target   <= i_target_slot;
        end
    end

    // Set, clear and retire slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_do_reg) begin
                r_valid[w_free_idx] <= 1'b1;
            end
            if (w_do_unreg) begin
                r_valid[w_tgt_idx] <= 1'b0;
            end
            if (w_wb_fire && !w_rd_per) begin
                r_valid[r_wb_idx] <= 1'b0;
            end
        end
    end

    // Write the slot memory from register or tick writeback
    always_ff @(posedge i_clk) begin
        if (w_do_reg) begin
            r_mem[w_free_idx] <= {r_periodic, r_timeout, TIMEOUT_W'(0)};
        end else if (w_wb_live) begin
            r_mem[r_wb_idx] <= {w_rd_per, w_rd_to, w_wb_cnt};
        end
    end

    // Read the slot memory one entry per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_scan_idx];
            r_wb_idx  <= r_scan_idx;
        end
    end

    // Advance the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= i_cmd.scan_step;
        end
    end

    // Build the pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_status <= 1'b0;
            r_res_slot   <= '0;
            r_res_mask   <= '0;
        end else begin
            if (i_cmd.exec && (r_op == OP_REGISTER)) begin
                r_res_status <= w_full;
                r_res_slot   <= w_full ? '0 : SLOT_FIELD_W'(w_free_idx);
            end
            r_res_mask <= r_res_mask | w_fire_bits;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_mask   <= r_res_mask;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_assigned_slot = r_out_slot;
    assign o_fired_mask    = r_out_mask;

    assign o_sts.op_tick   = (r_op == OP_TICK);
    assign o_sts.scan_last = (r_scan_idx == SLOT_W'(NUM_SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    // A writeback only follows a memory read
    a_wb_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> $past(i_cmd.scan_step))
        else $error("writeback without a preceding read");

    // A loaded result is presented on the next cycle
    a_load_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

    // A full-table result never carries a slot number
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_assigned_slot == '0))
        else $error("table full result with nonzero slot");

endmodule

[src/multi_slot_tick_timer_table.sv]
// Top level of the multi-slot tick timer table: controller plus datapath.
// Register, unregister and unknown requests: latch, execute, then load the output register.
// Tick requests: latch, execute, scan one slot per cycle, drain, then load the output register.
// One request in progress at a time: the next is accepted only after the last one's result
// has entered the output register.
// Synchronous active-low reset clears all slot valid bits and the handshake state.
`timescale 1ns / 1ps

module multi_slot_tick_timer_table import mstt_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [TIMEOUT_W-1:0]    i_timeout_ticks,
    input  logic                    i_periodic_mode,
    input  logic [SLOT_FIELD_W-1:0] i_target_slot,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_status,
    output logic [SLOT_FIELD_W-1:0] o_assigned_slot,
    output logic [MASK_W-1:0]       o_fired_mask
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence each request
    mstt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Hold slot state and build results
    mstt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_timeout_ticks (i_timeout_ticks),
        .i_periodic_mode (i_periodic_mode),
        .i_target_slot   (i_target_slot),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_assigned_slot (o_assigned_slot),
        .o_fired_mask    (o_fired_mask)
    );

endmodule
